/* hw/rtl/hexc_pkg.sv */
// shared constants and types for the cartesian to hex cell core
`timescale 1ns / 1ps

package hexc_pkg;

    localparam int POINT_W   = 32;
    localparam int COL_W     = 17;
    localparam int ROW_W     = 16;
    localparam int FRAC_W    = 16;
    localparam int IN_DATA_W = 2 * POINT_W;
    localparam int OUT_PAY_W = COL_W + ROW_W;
    localparam int OUT_DATA_W = ((OUT_PAY_W + 7) / 8) * 8;

    localparam int MAP_SCALE_DEF = 1;
    localparam int PIPE_DEPTH    = 6;

    // reciprocal divider
    localparam int DIV_NUM_W  = POINT_W + 1;
    localparam int RECIP_W    = 32;
    localparam int RECIP_BASE = 31;
    localparam longint SCALE_HALF = 64'sd2147483648;

    // hex geometry, alpha in q16.16
    localparam longint HEX_ALPHA  = 18919;
    localparam longint HEX_PERIOD = 6 * HEX_ALPHA;
    localparam int     PAIR_REM_W = $clog2(HEX_PERIOD + 1);
    localparam int     XC_W       = 16;
    localparam longint PAIR_OFS   = (SCALE_HALF + HEX_ALPHA + HEX_PERIOD - 1) / HEX_PERIOD;
    localparam longint PAIR_BIAS  = PAIR_OFS * HEX_PERIOD - HEX_ALPHA;

    localparam logic [DIV_NUM_W-1:0] PAIR_OFS_C  = DIV_NUM_W'(PAIR_OFS);
    localparam logic [DIV_NUM_W-1:0] PAIR_BIAS_C = DIV_NUM_W'(PAIR_BIAS);

    localparam logic [PAIR_REM_W-1:0] BAND_2A = PAIR_REM_W'(2 * HEX_ALPHA);
    localparam logic [PAIR_REM_W-1:0] BAND_3A = PAIR_REM_W'(3 * HEX_ALPHA);
    localparam logic [PAIR_REM_W-1:0] BAND_5A = PAIR_REM_W'(5 * HEX_ALPHA);
    localparam logic [PAIR_REM_W-1:0] BAND_6A = PAIR_REM_W'(6 * HEX_ALPHA);

    localparam int EDGE_W   = 2 * POINT_W;
    localparam int EDGE_P_W = 32;
    localparam int CMP_W    = PAIR_REM_W + FRAC_W + 15;
    localparam logic [FRAC_W-1:0]   EDGE_SLOPE = FRAC_W'(2 * HEX_ALPHA);
    localparam logic [CMP_W-1:0]    EDGE_FULL  = CMP_W'(2 * HEX_ALPHA * 65536);
    localparam logic [CMP_W-1:0]    EDGE_HALF  = CMP_W'(2 * HEX_ALPHA * 32768);

    localparam logic [1:0] COL_OFS_0 = 2'd0;
    localparam logic [1:0] COL_OFS_1 = 2'd1;
    localparam logic [1:0] COL_OFS_2 = 2'd2;

    typedef struct packed {
        logic ld_a;
        logic ld_b;
    } hexc_div_ctl_t;

endpackage

/* hw/rtl/hexc_floor_div.sv */
// two stage floor division of an unsigned word by a constant via reciprocal multiply
`timescale 1ns / 1ps

module hexc_floor_div
    import hexc_pkg::*;
#(
    parameter int DIVISOR = MAP_SCALE_DEF
)
(
    input  logic                               clk,
    input  hexc_div_ctl_t                      ctl,
    input  logic [DIV_NUM_W-1:0]               num,
    output logic [DIV_NUM_W-1:0]               quot,
    output logic [$clog2(DIVISOR + 1)-1:0]     rem
);

    localparam int SHIFT  = RECIP_BASE + $clog2(DIVISOR);
    localparam int REM_W  = $clog2(DIVISOR + 1);
    localparam int REM0_W = $clog2(5 * DIVISOR);
    localparam int PROD_W = DIV_NUM_W + RECIP_W;
    localparam int BACK_W = DIV_NUM_W + REM_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << SHIFT) / DIVISOR);

    logic [PROD_W-1:0]    prod;
    logic [PROD_W-1:0]    prod_sh;
    logic [DIV_NUM_W-1:0] q0_next;
    logic [DIV_NUM_W-1:0] q0_reg;
    logic [DIV_NUM_W-1:0] num_reg;
    logic [BACK_W-1:0]    back;
    logic [DIV_NUM_W-1:0] rem0_full;
    logic [REM0_W-1:0]    rem0;
    logic [REM0_W-1:0]    rem_fix;
    logic [2:0]           step;
    logic [DIV_NUM_W-1:0] quot_next;
    logic [DIV_NUM_W-1:0] quot_reg;
    logic [REM_W-1:0]     rem_next;
    logic [REM_W-1:0]     rem_reg;

    // estimate, low by at most four
    assign prod    = PROD_W'(num) * PROD_W'(RECIP);
    assign prod_sh = prod >> SHIFT;
    assign q0_next = prod_sh[DIV_NUM_W-1:0];

    always_ff @(posedge clk)
    begin
        if (ctl.ld_a)
        begin
            q0_reg  <= q0_next;
            num_reg <= num;
        end
    end

    assign back      = BACK_W'(q0_reg) * BACK_W'(DIVISOR);
    assign rem0_full = num_reg - back[DIV_NUM_W-1:0];
    assign rem0      = rem0_full[REM0_W-1:0];

    always_comb
    begin
        step = '0;
        for (int j = 1; j <= 4; j++)
        begin
            if (rem0 >= REM0_W'(j * DIVISOR))
            begin
                step = 3'(j);
            end
        end
    end

    assign rem_fix   = rem0 - REM0_W'(int'(step) * DIVISOR);
    assign rem_next  = rem_fix[REM_W-1:0];
    assign quot_next = q0_reg + DIV_NUM_W'(step);

    always_ff @(posedge clk)
    begin
        if (ctl.ld_b)
        begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
        end
    end

    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

/* hw/rtl/hexc_band.sv */
// band and edge tests inside the column pair period, result register
`timescale 1ns / 1ps

module hexc_band
    import hexc_pkg::*;
(
    input  logic                    clk,
    input  logic                    ld,
    input  logic [PAIR_REM_W-1:0]   r,
    input  logic [XC_W-1:0]         xc,
    input  logic [ROW_W-1:0]        yc,
    input  logic                    fhi,
    input  logic [EDGE_P_W-1:0]     p,
    output logic [COL_W-1:0]        cell_column,
    output logic [ROW_W-1:0]        cell_row
);

    logic [PAIR_REM_W-1:0] d2;
    logic [PAIR_REM_W-1:0] d5;
    logic [PAIR_REM_W-1:0] d6;
    logic [CMP_W-1:0]      p_w;
    logic [CMP_W-1:0]      p_rest;
    logic [CMP_W-1:0]      p_half;
    logic [CMP_W-1:0]      d2_w;
    logic [CMP_W-1:0]      d5_w;
    logic [CMP_W-1:0]      d6_w;
    logic [1:0]            xo;
    logic                  yo;
    logic [COL_W-1:0]      col_next;
    logic [ROW_W-1:0]      row_next;
    logic [COL_W-1:0]      col_reg;
    logic [ROW_W-1:0]      row_reg;

    assign d2 = r - BAND_2A;
    assign d5 = r - BAND_5A;
    assign d6 = BAND_6A - r;

    assign p_w    = CMP_W'(p);
    assign p_rest = EDGE_FULL - p_w;
    assign p_half = p_w - EDGE_HALF;
    assign d2_w   = CMP_W'({d2, FRAC_W'(0)});
    assign d5_w   = CMP_W'({d5, FRAC_W'(0)});
    assign d6_w   = CMP_W'({d6, FRAC_W'(0)});

    always_comb
    begin
        xo = COL_OFS_0;
        yo = 1'b0;
        if (r < BAND_2A)
        begin
            xo = COL_OFS_0;
            yo = 1'b0;
        end
        else if (r >= BAND_3A && r < BAND_5A)
        begin
            xo = COL_OFS_1;
            yo = fhi;
        end
        else if (r < BAND_3A)
        begin
            if (!fhi)
            begin
                xo = (p_w <= d2_w) ? COL_OFS_1 : COL_OFS_0;
                yo = 1'b0;
            end
            else if (p_rest > d2_w)
            begin
                xo = COL_OFS_0;
                yo = 1'b0;
            end
            else
            begin
                xo = COL_OFS_1;
                yo = 1'b1;
            end
        end
        else if (!fhi)
        begin
            xo = (p_w <= d6_w) ? COL_OFS_1 : COL_OFS_2;
            yo = 1'b0;
        end
        else if (p_half <= d5_w)
        begin
            xo = COL_OFS_2;
            yo = 1'b0;
        end
        else
        begin
            xo = COL_OFS_1;
            yo = 1'b1;
        end
    end

    assign col_next = {xc, 1'b0} + COL_W'(xo);

    // row saturates at the top of its range
    always_comb
    begin
        if (yo && yc == {1'b0, {(ROW_W-1){1'b1}}})
        begin
            row_next = yc;
        end
        else
        begin
            row_next = yc + ROW_W'(yo);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign cell_column = col_reg;
    assign cell_row    = row_reg;

endmodule

/* hw/rtl/cartesian_to_hex_cell_core.sv */
// top level: point to flat-topped hex cell pipeline with stream ports
`timescale 1ns / 1ps

// Maps a signed q16.16 point (x in the low word of s_tdata, y in the high word) to the
// flat-topped hex cell holding it, in offset coordinates. One beat is taken every clock unless
// back pressure has filled the pipeline; the six stages are the input register, two stages
// for the reciprocal divide by MAP_SCALE, two for the reciprocal divide by the column pair
// period, and the band test feeding the result register. Back pressure on m_tready stalls
// only as far as needed: empty stages keep filling while a result waits.

module cartesian_to_hex_cell_core
    import hexc_pkg::*;
#(
    parameter int MAP_SCALE = MAP_SCALE_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // point_x, point_y
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // cell_column, cell_row, zero pad
);

    localparam longint SCALE_RD = SCALE_HALF % MAP_SCALE;
    localparam logic [DIV_NUM_W-1:0] SCALE_K =
        DIV_NUM_W'((SCALE_RD == 0) ? 0 : (MAP_SCALE - SCALE_RD));
    localparam logic [DIV_NUM_W-1:0] SCALE_ADJ =
        DIV_NUM_W'(SCALE_HALF / MAP_SCALE + ((SCALE_RD != 0) ? 1 : 0));

    logic [PIPE_DEPTH-1:0] valid_reg;
    logic [PIPE_DEPTH-1:0] valid_next;
    logic [PIPE_DEPTH:0]   ready;
    logic [PIPE_DEPTH:0]   valid_in;

    logic [POINT_W-1:0]    x_reg;
    logic [POINT_W-1:0]    y_reg;
    logic [DIV_NUM_W-1:0]  x_num;
    logic [DIV_NUM_W-1:0]  y_num;
    logic [DIV_NUM_W-1:0]  x_quot;
    logic [DIV_NUM_W-1:0]  y_quot;
    logic [DIV_NUM_W-1:0]  xs_full;
    logic [DIV_NUM_W-1:0]  ys_full;
    logic [DIV_NUM_W-1:0]  pair_num;
    logic [DIV_NUM_W-1:0]  pair_quot;
    logic [PAIR_REM_W-1:0] pair_rem;
    logic [DIV_NUM_W-1:0]  xc_full;

    logic [ROW_W-1:0]      yc_s3_reg;
    logic                  fhi_s3_reg;
    logic [EDGE_P_W-1:0]   p_s3_reg;
    logic [ROW_W-1:0]      yc_s4_reg;
    logic                  fhi_s4_reg;
    logic [EDGE_P_W-1:0]   p_s4_reg;
    logic [EDGE_P_W-1:0]   p_next;

    logic [COL_W-1:0]      cell_column;
    logic [ROW_W-1:0]      cell_row;

    hexc_div_ctl_t         scale_ctl;
    hexc_div_ctl_t         pair_ctl;

    // per-stage ready, a stage loads when empty or when the next one loads
    assign valid_in = {valid_reg, s_tvalid};

    always_comb
    begin
        ready[PIPE_DEPTH] = m_tready;
        for (int k = PIPE_DEPTH - 1; k >= 0; k--)
        begin
            ready[k] = !valid_reg[k] || ready[k+1];
        end
        for (int k = 0; k < PIPE_DEPTH; k++)
        begin
            valid_next[k] = ready[k] ? valid_in[k] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = ready[0];
    assign m_tvalid = valid_reg[PIPE_DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (ready[0])
        begin
            x_reg <= s_tdata[POINT_W-1:0];
            y_reg <= s_tdata[IN_DATA_W-1:POINT_W];
        end
    end

    // offset binary makes the dividend non-negative
    assign x_num = {1'b0, ~x_reg[POINT_W-1], x_reg[POINT_W-2:0]} + SCALE_K;
    assign y_num = {1'b0, ~y_reg[POINT_W-1], y_reg[POINT_W-2:0]} + SCALE_K;

    assign scale_ctl = '{ld_a: ready[1], ld_b: ready[2]};
    assign pair_ctl  = '{ld_a: ready[3], ld_b: ready[4]};

    hexc_floor_div #(
        .DIVISOR (MAP_SCALE)
    ) u_scale_x (
        .clk  (clk),
        .ctl  (scale_ctl),
        .num  (x_num),
        .quot (x_quot),
        .rem  ()
    );

    hexc_floor_div #(
        .DIVISOR (MAP_SCALE)
    ) u_scale_y (
        .clk  (clk),
        .ctl  (scale_ctl),
        .num  (y_num),
        .quot (y_quot),
        .rem  ()
    );

    assign xs_full  = x_quot - SCALE_ADJ;
    assign ys_full  = y_quot - SCALE_ADJ;
    assign pair_num = {xs_full[POINT_W-1], xs_full[POINT_W-1:0]} + PAIR_BIAS_C;

    hexc_floor_div #(
        .DIVISOR (int'(HEX_PERIOD))
    ) u_pair (
        .clk  (clk),
        .ctl  (pair_ctl),
        .num  (pair_num),
        .quot (pair_quot),
        .rem  (pair_rem)
    );

    assign p_next = EDGE_P_W'(ys_full[FRAC_W-1:0]) * EDGE_P_W'(EDGE_SLOPE);

    always_ff @(posedge clk)
    begin
        if (ready[3])
        begin
            yc_s3_reg  <= ys_full[POINT_W-1:FRAC_W];
            fhi_s3_reg <= ys_full[FRAC_W-1];
            p_s3_reg   <= p_next;
        end
        if (ready[4])
        begin
            yc_s4_reg  <= yc_s3_reg;
            fhi_s4_reg <= fhi_s3_reg;
            p_s4_reg   <= p_s3_reg;
        end
    end

    assign xc_full = pair_quot - PAIR_OFS_C;

    hexc_band u_band (
        .clk         (clk),
        .ld          (ready[5]),
        .r           (pair_rem),
        .xc          (xc_full[XC_W-1:0]),
        .yc          (yc_s4_reg),
        .fhi         (fhi_s4_reg),
        .p           (p_s4_reg),
        .cell_column (cell_column),
        .cell_row    (cell_row)
    );

    assign m_tdata = {{(OUT_DATA_W - OUT_PAY_W){1'b0}}, cell_row, cell_column};

endmodule

/* hw/rtl/hexc_checker.sv */
// port level checks for the cartesian to hex cell core, bound to the top level
`timescale 1ns / 1ps

module hexc_checker
    import hexc_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [IN_DATA_W-1:0]  s_tdata,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // offered input beat holds until taken
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
        else $error("input beat changed while stalled");

    // input side only stalls when a result is waiting
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output back pressure");

    // pad bits of a result beat are zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[OUT_DATA_W-1:OUT_PAY_W] == '0)
        else $error("nonzero pad in result beat");

    // a beat offered with room is taken
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input not ready while output drains");

endmodule

bind cartesian_to_hex_cell_core hexc_checker u_hexc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
